// ===== rtl/rta_pkg.sv =====
// Shared types and constants for the radix to ASCII formatter.
// No dependencies; imported by every module of the block.
package rta_pkg;

   localparam int LEN_W = 6;

   localparam logic [1:0] OP_HEX = 2'd0;
   localparam logic [1:0] OP_OCT = 2'd1;
   localparam logic [1:0] OP_BIN = 2'd2;

   localparam logic [7:0] LIMIT_RESET = 8'd255;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [3:0] DIGIT_MASK  = 4'hF;
   localparam logic [3:0] GROUP_BITS  = 4'd8;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0]       character;
      logic             char_valid;
      logic             last;
      logic [LEN_W-1:0] length;
   } rsp_type;

endpackage

// ===== rtl/rta_measure.sv =====
// Length and first digit position of one conversion, with the output limit applied.
// Depends on rta_pkg.
module rta_measure import rta_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int POS_W = 5
) (
   input  logic [1:0]            operation,
   input  logic [VALUE_BITS-1:0] value,
   input  logic [7:0]            output_limit,
   output logic [LEN_W-1:0]      length,
   output logic [POS_W-1:0]      start_pos
);

   localparam int PW = $clog2(VALUE_BITS);

   logic [PW-1:0] msb;
   logic [PW+6:0] oct_prod;
   logic [7:0]    hex_last;
   logic [7:0]    oct_last;
   logic [7:0]    nbytes;
   logic [7:0]    raw_len;
   logic [7:0]    cap;

   // Highest set bit; zero maps to position 0
   always_comb begin
      msb = '0;
      for (int i = 0; i < VALUE_BITS; i++) begin
         if (value[i]) msb = PW'(i);
      end
   end

   // msb / 3 by reciprocal, exact for msb below 64
   assign oct_prod = (PW+7)'(msb) * (PW+7)'(43);
   assign hex_last = 8'(msb >> 2);
   assign oct_last = 8'(oct_prod >> 7);
   assign nbytes   = 8'(msb >> 3) + 8'd1;

   always_comb begin
      case (operation)
         OP_HEX: begin
            raw_len   = hex_last + 8'd1;
            start_pos = POS_W'(hex_last);
         end
         OP_OCT: begin
            raw_len   = oct_last + 8'd1;
            start_pos = POS_W'(oct_last);
         end
         OP_BIN: begin
            raw_len   = 8'(nbytes * 8'd9) - 8'd1;
            start_pos = POS_W'({(msb >> 3), 3'b111});
         end
         default: begin
            raw_len   = 8'd0;
            start_pos = '0;
         end
      endcase
   end

   // A zero limit behaves like one
   assign cap    = (output_limit == 8'd0) ? 8'd0 : output_limit - 8'd1;
   assign length = LEN_W'((raw_len > cap) ? cap : raw_len);

endmodule

// ===== rtl/radix_to_ascii_formatter.sv =====
// Top level of the radix to ASCII formatter: input capture, character sequencer and
// output register. Depends on rta_pkg and rta_measure.
//
// Usage:
//   req_ carries one word per conversion: a mode (hex, octal, binary with byte
//   groups) and a value. rsp_ returns one word per ASCII character, most
//   significant first; the final word has last set and carries the length.
//   A conversion with no characters (unused mode, or limit of 0 or 1) returns
//   one word with char_valid low and last high.
//   csr_wr_en / csr_wr_data set the output limit (characters = limit - 1).
//   An accepted word is held in the input capture registers, from which its first
//   character moves to the output register. While rsp_ready is high, characters
//   leave one per cycle, and a conversion returns max(length, 1) words: up to 35
//   for a 32-bit binary value. The next req_ word is taken in the cycle the last
//   character of the current one moves to the output register.
//   Reset empties both registers and sets the limit to 255.
//   When the receiver drops rsp_ready the output word holds, the sequencer
//   stalls, and req_ready stays low until the current conversion drains.
module radix_to_ascii_formatter import rta_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int POS_W = $clog2(((VALUE_BITS + 7) / 8) * 8);

   logic [7:0]            limit_ff;
   logic                  busy_ff, busy_in;
   logic [1:0]            op_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  space_ff, space_in;
   logic [LEN_W-1:0]      cnt_ff, cnt_in;
   logic [LEN_W-1:0]      len_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [VALUE_BITS-1:0] req_value;
   logic [LEN_W-1:0]      req_len;
   logic [POS_W-1:0]      req_pos;
   logic                  req_take;
   logic                  out_free;
   logic                  issue;
   logic                  is_last;
   logic [POS_W+1:0]      shift_amt;
   logic [VALUE_BITS-1:0] shifted;
   logic [3:0]            digit;
   logic [7:0]            char_code;

   // Keep the low VALUE_BITS of the input value, zero above 32
   always_comb begin
      req_value = '0;
      for (int i = 0; i < VALUE_BITS; i++) begin
         if (i < 32) req_value[i] = req_data.value[i];
      end
   end

   rta_measure #(
      .VALUE_BITS (VALUE_BITS),
      .POS_W      (POS_W)
   ) u_measure (
      .operation    (req_data.operation),
      .value        (req_value),
      .output_limit (limit_ff),
      .length       (req_len),
      .start_pos    (req_pos)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign issue     = busy_ff && out_free;
   assign is_last   = (len_ff == '0) || (cnt_ff == len_ff - LEN_W'(1));
   assign req_ready = !busy_ff || (issue && is_last);
   assign req_take  = req_valid && req_ready;

   // Digit select: hex nibble, octal triple or single bit at pos_ff
   always_comb begin
      case (op_ff)
         OP_HEX:  shift_amt = {pos_ff, 2'b00};
         OP_OCT:  shift_amt = (POS_W+2)'({pos_ff, 1'b0}) + (POS_W+2)'(pos_ff);
         default: shift_amt = (POS_W+2)'(pos_ff);
      endcase
   end

   assign shifted = val_ff >> shift_amt;

   always_comb begin
      case (op_ff)
         OP_HEX:  digit = shifted[3:0] & DIGIT_MASK;
         OP_OCT:  digit = {1'b0, shifted[2:0]};
         default: digit = {3'b000, shifted[0]};
      endcase
      if (op_ff == OP_BIN && space_ff) begin
         char_code = CHAR_SPACE;
      end else if (digit < 4'd10) begin
         char_code = CHAR_ZERO + 8'(digit);
      end else begin
         char_code = CHAR_A + 8'(digit) - 8'd10;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      space_in     = space_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (issue) begin
         rsp_valid_in = 1'b1;
         if (len_ff == '0) begin
            rsp_in = '{character: 8'd0, char_valid: 1'b0, last: 1'b1, length: '0};
         end else begin
            rsp_in.character  = char_code;
            rsp_in.char_valid = 1'b1;
            rsp_in.last       = is_last;
            rsp_in.length     = is_last ? len_ff : '0;
         end
         cnt_in = cnt_ff + LEN_W'(1);
         // Binary inserts a space after each byte boundary bit, then advances
         if (op_ff == OP_BIN && !space_ff && pos_ff[2:0] == 3'd0 && pos_ff != '0) begin
            space_in = 1'b1;
         end else begin
            space_in = 1'b0;
            pos_in   = pos_ff - POS_W'(1);
         end
         if (is_last) busy_in = 1'b0;
      end

      if (req_take) begin
         busy_in  = 1'b1;
         pos_in   = req_pos;
         space_in = 1'b0;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      space_ff <= space_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
      if (req_take) begin
         op_ff  <= req_data.operation;
         val_ff <= req_value;
         len_ff <= req_len;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
